// File: rtl/csv_tile_id_parser_unit_defines.svh
// assertion helpers for the csv tile id parser
`ifndef CSV_TILE_ID_PARSER_UNIT_DEFINES_SVH
`define CSV_TILE_ID_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CSVTID_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("csvtid same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define CSVTID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("csvtid next-cycle check failed");

`endif

// File: rtl/csvtid_pkg.sv
package csvtid_pkg;

    localparam int unsigned MAX_TILES_DEF = 65536;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned TILE_W   = 16;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned EXP_W    = 17;

    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [VALUE_W-1:0]  t_value;
    typedef logic [TILE_W-1:0]   t_tile;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [EXP_W-1:0]    t_expected;
    typedef logic [1:0]          t_phase;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic KIND_TILE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam t_status ST_OK      = 3'd0;
    localparam t_status ST_NOT_INT = 3'd1;
    localparam t_status ST_FLIP    = 3'd2;
    localparam t_status ST_LARGE   = 3'd3;
    localparam t_status ST_COUNT   = 3'd4;

    localparam t_phase PH_LEAD   = 2'd0;
    localparam t_phase PH_DIGITS = 2'd1;
    localparam t_phase PH_TRAIL  = 2'd2;
    localparam t_phase PH_BAD    = 2'd3;

    localparam t_value ID_MASK   = 32'h0FFF_FFFF;
    localparam t_value FLAG_BITS = 32'hF000_0000;
    localparam t_value TILE_MAX  = 32'h0000_FFFF;
    localparam t_char  SEPARATOR = 8'h2C;
    localparam t_char  CHAR_ZERO = 8'h30;
    localparam t_char  CHAR_NINE = 8'h39;

    typedef struct packed {
        logic    kind;
        t_tile   tile_id;
        t_status status;
        logic    last;
    } t_result;

    // results produced by one processed item, tile first
    typedef struct packed {
        logic    push_tile;
        t_tile   tile_id;
        logic    push_status;
        t_status status;
    } t_push;

    function automatic logic is_space(input t_char c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

// File: rtl/csvtid_ifs.sv
interface csvtid_in_if;
    logic                 valid;
    logic                 ready;
    logic                 operation;
    csvtid_pkg::t_char    character;

    modport source (output valid, output operation, output character, input ready);
    modport sink   (input valid, input operation, input character, output ready);
endinterface

interface csvtid_out_if;
    logic                 valid;
    logic                 ready;
    logic                 kind;
    csvtid_pkg::t_tile    tile_id;
    csvtid_pkg::t_status  status;
    logic                 last;

    modport source (output valid, output kind, output tile_id, output status, output last,
                    input ready);
    modport sink   (input valid, input kind, input tile_id, input status, input last,
                    output ready);
endinterface

// File: rtl/csvtid_parse.sv
module csvtid_parse #(
    parameter int unsigned MAX_TILES = csvtid_pkg::MAX_TILES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic                  i_operation,
    input  csvtid_pkg::t_char     i_character,
    input  csvtid_pkg::t_expected i_expected_tiles,
    output csvtid_pkg::t_push     o_push,
    output logic [1:0]            o_push_count
);
    import csvtid_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_TILES + 1);
    localparam int unsigned CMP_W = (CNT_W > EXP_W) ? CNT_W : EXP_W;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_TILES);

    t_value           r_token_value, n_token_value;
    t_phase           r_token_phase, n_token_phase;
    logic [CNT_W-1:0] r_tile_count,  n_tile_count;
    t_status          r_first_error, n_first_error;

    logic        w_space;
    logic        w_digit;
    logic        w_finish;
    logic [35:0] w_scaled;

    assign w_space = is_space(i_character);
    assign w_digit = (i_character >= CHAR_ZERO) && (i_character <= CHAR_NINE);
    // value * 10 + digit, top four bits flag a 32-bit overflow
    assign w_scaled = ({4'b0000, r_token_value} << 3) + ({4'b0000, r_token_value} << 1)
                    + {32'd0, i_character[3:0]};

    always_comb begin
        n_token_value = r_token_value;
        n_token_phase = r_token_phase;
        n_tile_count  = r_tile_count;
        n_first_error = r_first_error;
        o_push        = '0;
        w_finish      = 1'b0;

        if (i_operation == OP_CHAR) begin
            if (r_first_error == ST_OK) begin
                if (i_character == SEPARATOR) begin
                    w_finish = 1'b1;
                end else if (w_space) begin
                    if (r_token_phase == PH_DIGITS) begin
                        n_token_phase = PH_TRAIL;
                    end
                end else if (w_digit) begin
                    if ((r_token_phase == PH_LEAD) || (r_token_phase == PH_DIGITS)) begin
                        if (w_scaled[35:32] != 4'd0) begin
                            n_token_phase = PH_BAD;
                        end else begin
                            n_token_value = w_scaled[31:0];
                            n_token_phase = PH_DIGITS;
                        end
                    end else begin
                        n_token_phase = PH_BAD;
                    end
                end else begin
                    n_token_phase = PH_BAD;
                end
            end
        end else begin
            w_finish = 1'b1;
        end

        if (w_finish) begin
            if (r_first_error == ST_OK) begin
                if (r_token_phase == PH_BAD) begin
                    n_first_error = ST_NOT_INT;
                end else if (r_token_phase != PH_LEAD) begin
                    if ((r_token_value & FLAG_BITS) != '0) begin
                        n_first_error = ST_FLIP;
                    end else if ((r_token_value & ID_MASK) > TILE_MAX) begin
                        n_first_error = ST_LARGE;
                    end else if (r_tile_count >= CNT_LIMIT) begin
                        n_first_error = ST_COUNT;
                    end else begin
                        n_tile_count     = r_tile_count + CNT_W'(1);
                        o_push.push_tile = 1'b1;
                        o_push.tile_id   = r_token_value[TILE_W-1:0];
                    end
                end
            end
            n_token_value = '0;
            n_token_phase = PH_LEAD;
        end

        if (i_operation == OP_END) begin
            o_push.push_status = 1'b1;
            if (n_first_error != ST_OK) begin
                o_push.status = n_first_error;
            end else if (CMP_W'(n_tile_count) != CMP_W'(i_expected_tiles)) begin
                o_push.status = ST_COUNT;
            end else begin
                o_push.status = ST_OK;
            end
            n_tile_count  = '0;
            n_first_error = ST_OK;
        end
    end

    assign o_push_count = {1'b0, o_push.push_tile} + {1'b0, o_push.push_status};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_value <= '0;
            r_token_phase <= PH_LEAD;
            r_tile_count  <= '0;
            r_first_error <= ST_OK;
        end else if (i_advance) begin
            r_token_value <= n_token_value;
            r_token_phase <= n_token_phase;
            r_tile_count  <= n_tile_count;
            r_first_error <= n_first_error;
        end
    end

endmodule

// File: rtl/csvtid_outq.sv
module csvtid_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_en,
    input  csvtid_pkg::t_push i_push,
    csvtid_out_if.source      o_res,
    output logic [1:0]        o_free
);
    import csvtid_pkg::*;

    t_result    r_q [2];
    t_result    n_q [2];
    logic [1:0] r_count, n_count;
    logic       w_pop;
    logic [1:0] w_base;
    logic       w_idx;

    assign w_pop  = (r_count != 2'd0) && o_res.ready;
    assign w_base = r_count - {1'b0, w_pop};

    always_comb begin
        n_q[0]  = r_q[0];
        n_q[1]  = r_q[1];
        n_count = w_base;
        w_idx   = w_base[0];
        if (w_pop) begin
            n_q[0] = r_q[1];
        end
        if (i_push_en) begin
            if (i_push.push_tile) begin
                n_q[w_idx] = '{kind: KIND_TILE, tile_id: i_push.tile_id,
                               status: ST_OK, last: 1'b0};
                w_idx      = w_idx + 1'b1;
                n_count    = n_count + 2'd1;
            end
            if (i_push.push_status) begin
                n_q[w_idx] = '{kind: KIND_STATUS, tile_id: '0,
                               status: i_push.status, last: 1'b1};
                n_count    = n_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    assign o_res.valid   = (r_count != 2'd0);
    assign o_res.kind    = r_q[0].kind;
    assign o_res.tile_id = r_q[0].tile_id;
    assign o_res.status  = r_q[0].status;
    assign o_res.last    = r_q[0].last;
    // space counted without this cycle's transfer, keeps ready off the output path
    assign o_free        = 2'd2 - r_count;

endmodule

// File: rtl/csv_tile_id_parser_unit.sv
// Comma-separated tile id parser. One text byte or end-of-text marker is
// taken per transfer on i_in; each byte may be accepted every clock while
// the output queue has room. A byte is held in the input register, parsed
// against the token state (one multiply-by-ten add and overflow check), and
// its results are registered into a two-entry output queue that drives
// o_res. Ordinary bytes give at most one result and stream at one item per
// cycle while o_res is ready. An end item that also closes a tile id gives
// two results (the tile, then the status with last set); the queue holds
// both, and the input takes the next item once the output side has drained
// enough room. Write expected_tiles through i_cfg_wr_en/i_cfg_wr_data only
// while idle; it is used at the next end of text.
`include "csv_tile_id_parser_unit_defines.svh"

module csv_tile_id_parser_unit #(
    parameter int unsigned MAX_TILES = csvtid_pkg::MAX_TILES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    csvtid_in_if.sink             i_in,
    csvtid_out_if.source          o_res,
    input  logic                  i_cfg_wr_en,
    input  csvtid_pkg::t_expected i_cfg_wr_data
);
    import csvtid_pkg::*;

    logic      r_in_valid;
    logic      r_in_op;
    t_char     r_in_char;
    t_expected r_expected_tiles;

    t_push      w_push;
    logic [1:0] w_push_count;
    logic [1:0] w_free;
    logic       w_advance;

    assign w_advance  = r_in_valid && (w_push_count <= w_free);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_op   <= i_in.operation;
            r_in_char <= i_in.character;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_tiles <= '0;
        end else if (i_cfg_wr_en) begin
            r_expected_tiles <= i_cfg_wr_data;
        end
    end

    csvtid_parse #(
        .MAX_TILES (MAX_TILES)
    ) u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (w_advance),
        .i_operation      (r_in_op),
        .i_character      (r_in_char),
        .i_expected_tiles (r_expected_tiles),
        .o_push           (w_push),
        .o_push_count     (w_push_count)
    );

    csvtid_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (w_advance),
        .i_push    (w_push),
        .o_res     (o_res),
        .o_free    (w_free)
    );

    `CSVTID_ASSERT_NEXT(a_end_gives_result, i_clk, i_rst_n, w_advance && (r_in_op == OP_END), o_res.valid)
    `CSVTID_ASSERT_IMPLY(a_tile_fields, i_clk, i_rst_n, o_res.valid && (o_res.kind == KIND_TILE), !o_res.last && (o_res.status == ST_OK))
    `CSVTID_ASSERT_IMPLY(a_status_fields, i_clk, i_rst_n, o_res.valid && (o_res.kind == KIND_STATUS), o_res.last && (o_res.tile_id == '0))
    `CSVTID_ASSERT_NEXT(a_stalled_item_held, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid && $stable(r_in_op) && $stable(r_in_char))

endmodule
